FILE: hdl/dcqcn_rc_pkg.sv
// ----------------------------------------------------------------------------
// dcqcn_rc_pkg
// Types and constants shared by the reaction point rate controller modules.
// ----------------------------------------------------------------------------
package dcqcn_rc_pkg;

  localparam int FLOW_W  = 6;
  localparam int RATE_W  = 20;
  localparam int ALPHA_W = 17;
  localparam int STAGE_W = 8;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ALPHA_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [ALPHA_W:0]   TWO_Q16   = 18'd131072;
  localparam logic [STAGE_W-1:0] STAGE_AI  = 8'd5;
  localparam logic [STAGE_W-1:0] STAGE_MAX = 8'd255;

  localparam logic [ALPHA_W-1:0] GAIN_RESET = 17'd256;
  localparam logic [ALPHA_W-1:0] FRAC_RESET = 17'd655;
  localparam logic [RATE_W-1:0]  STEP_RESET = 20'd5000;
  localparam logic [RATE_W-1:0]  LINE_RESET = 20'd100000;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_FRAC = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;
  localparam logic [1:0] REG_LINE = 2'd3;

  typedef enum logic {
    OP_CNP  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic              op;
    logic [FLOW_W-1:0] flow_index;
  } evt_t;

  typedef struct packed {
    logic [FLOW_W-1:0]  flow_echo;
    logic [RATE_W-1:0]  current_rate;
    logic [RATE_W-1:0]  target_rate;
    logic [ALPHA_W-1:0] alpha_level;
    logic               start_timer;
  } upd_t;

  typedef struct packed {
    op_t               op;
    logic [FLOW_W-1:0] flow;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic clearing;
  } bstat_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] gain;
    logic [ALPHA_W-1:0] frac;
    logic [RATE_W-1:0]  step;
    logic [RATE_W-1:0]  line;
  } cfg_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [RATE_W-1:0]  cur;
    logic [RATE_W-1:0]  tgt;
    logic [STAGE_W-1:0] stage;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{alpha: ONE_Q16, cur: LINE_RESET,
                                     tgt: LINE_RESET, stage: '0};

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_CALC,
    BK_CUT,
    BK_DONE
  } back_state_t;

endpackage

FILE: hdl/dcqcn_rc_regs.sv
// ----------------------------------------------------------------------------
// dcqcn_rc_regs
// Configuration registers behind an APB-style port, with read back.
// ----------------------------------------------------------------------------
module dcqcn_rc_regs
  import dcqcn_rc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain <= GAIN_RESET;
      cfg.frac <= FRAC_RESET;
      cfg.step <= STEP_RESET;
      cfg.line <= LINE_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN: cfg.gain <= pwdata[ALPHA_W-1:0];
        REG_FRAC: cfg.frac <= pwdata[ALPHA_W-1:0];
        REG_STEP: cfg.step <= pwdata[RATE_W-1:0];
        REG_LINE: cfg.line <= pwdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN: prdata = CFG_DW'(cfg.gain);
      REG_FRAC: prdata = CFG_DW'(cfg.frac);
      REG_STEP: prdata = CFG_DW'(cfg.step);
      REG_LINE: prdata = CFG_DW'(cfg.line);
      default:  prdata = '0;
    endcase
  end

endmodule

FILE: hdl/dcqcn_rc_front.sv
// ----------------------------------------------------------------------------
// dcqcn_rc_front
// Accepts events, drops flows outside the table and classifies the rest.
// ----------------------------------------------------------------------------
module dcqcn_rc_front
  import dcqcn_rc_pkg::*;
#(
  parameter int FLOWS = 64
) (
  input  logic   push,
  output logic   full,
  input  evt_t   notice,
  input  qstat_t qstat,
  input  bstat_t bstat,
  output logic   q_wr,
  output cls_t   q_item
);

  logic in_range;

  assign full     = qstat.full || bstat.clearing;
  assign in_range = 13'(notice.flow_index) < 13'(FLOWS);
  assign q_wr     = push && !full && in_range;

  assign q_item.op   = (notice.op == 1'b1) ? OP_TICK : OP_CNP;
  assign q_item.flow = notice.flow_index;

endmodule

FILE: hdl/dcqcn_rc_queue.sv
// ----------------------------------------------------------------------------
// dcqcn_rc_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module dcqcn_rc_queue
  import dcqcn_rc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  cls_t   wr_item,
  input  logic   rd,
  output cls_t   rd_item,
  output qstat_t stat
);

  cls_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;
  logic              wr_ok;
  logic              rd_ok;

  assign stat.full  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt == '0);
  assign wr_ok      = wr && !stat.full;
  assign rd_ok      = rd && !stat.empty;
  assign rd_item    = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_ok) begin
        wp <= (wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd_ok) begin
        rp <= (rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({wr_ok, rd_ok})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      slots[wp] <= wr_item;
    end
  end

endmodule

FILE: hdl/dcqcn_rc_back.sv
// ----------------------------------------------------------------------------
// dcqcn_rc_back
// Per-flow state memory, rate update sequencer and result register.
// ----------------------------------------------------------------------------
module dcqcn_rc_back
  import dcqcn_rc_pkg::*;
#(
  parameter int FLOWS = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  qstat_t qstat,
  input  cls_t   q_head,
  output logic   q_pop,
  output bstat_t bstat,
  output logic   empty,
  input  logic   pop,
  output upd_t   update
);

  localparam int AW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  back_state_t state;
  back_state_t state_next;

  entry_t mem [FLOWS];
  entry_t rd_data;
  entry_t wr_data;
  entry_t entry_new;

  cls_t            item;
  logic [AW-1:0]   clr_addr;
  logic            clr_last;
  logic [AW+5:0]   head_wide;
  logic [AW+5:0]   item_wide;
  logic [AW-1:0]   head_addr;
  logic [AW-1:0]   item_addr;
  logic [AW-1:0]   wr_addr;
  logic            mem_we;
  logic            out_load;
  logic            out_valid;
  logic            slot_free;
  upd_t            out_next;

  logic [ALPHA_W-1:0] g_eff;
  logic [ALPHA_W-1:0] frac_eff;
  logic [RATE_W-1:0]  line_eff;
  logic [ALPHA_W-1:0] one_minus_g;

  logic [33:0]        prod_alpha;
  logic [36:0]        prod_min;
  logic [ALPHA_W-1:0] alpha_new;
  logic [RATE_W:0]    minr;
  logic [RATE_W-1:0]  tgt_new;
  logic [37:0]        prod_cut;
  logic [RATE_W-1:0]  cur_tick;

  logic [34:0]        alpha_sum;
  logic [ALPHA_W-1:0] alpha_c;
  logic [ALPHA_W-1:0] alpha_t;
  logic [RATE_W:0]    tgt_sum;
  logic [RATE_W-1:0]  tgt_t;
  logic [RATE_W:0]    minr_raw;
  logic [RATE_W:0]    cur_sum;
  logic [RATE_W-1:0]  cur_half;
  logic [RATE_W:0]    cut;
  logic [RATE_W:0]    cur_cnp;
  logic [RATE_W-1:0]  cur_final;
  logic [STAGE_W-1:0] stage_final;
  logic               timer;

  // effective configuration
  assign g_eff       = (cfg.gain > ONE_Q16) ? ONE_Q16 : cfg.gain;
  assign frac_eff    = (cfg.frac > ONE_Q16) ? ONE_Q16 : cfg.frac;
  assign line_eff    = (cfg.line == '0) ? RATE_W'(1) : cfg.line;
  assign one_minus_g = ONE_Q16 - g_eff;

  assign head_wide = {{AW{1'b0}}, q_head.flow};
  assign item_wide = {{AW{1'b0}}, item.flow};
  assign head_addr = head_wide[AW-1:0];
  assign item_addr = item_wide[AW-1:0];
  assign clr_last  = (clr_addr == AW'(FLOWS - 1));
  assign slot_free = !out_valid || pop;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr_last) state_next = BK_IDLE;
      BK_IDLE:  if (!qstat.empty) state_next = BK_READ;
      BK_READ:  state_next = BK_CALC;
      BK_CALC:  state_next = BK_CUT;
      BK_CUT:   state_next = BK_DONE;
      BK_DONE:  if (slot_free) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    bstat.clearing = 1'b0;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    mem_we         = 1'b0;
    case (state)
      BK_CLEAR: begin
        bstat.clearing = 1'b1;
        mem_we         = 1'b1;
      end
      BK_IDLE: q_pop = !qstat.empty;
      BK_DONE: begin
        out_load = slot_free;
        mem_we   = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (bstat.clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // state memory
  assign wr_addr = bstat.clearing ? clr_addr : item_addr;
  assign wr_data = bstat.clearing ? ENTRY_RESET : entry_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data <= mem[head_addr];
      item    <= q_head;
    end
  end

  // arithmetic
  assign alpha_sum = {1'b0, prod_alpha} + {2'b00, g_eff, 16'h0000};
  assign alpha_c   = (alpha_sum[34:16] > 19'(ONE_Q16)) ? ONE_Q16 : alpha_sum[32:16];
  assign alpha_t   = prod_alpha[32:16];
  assign tgt_sum   = {1'b0, rd_data.tgt} + {1'b0, cfg.step};
  assign tgt_t     = (rd_data.stage < STAGE_AI) ? rd_data.tgt :
                     (tgt_sum > {1'b0, line_eff}) ? line_eff : tgt_sum[RATE_W-1:0];
  assign minr_raw  = prod_min[36:16];
  assign cur_sum   = {1'b0, rd_data.cur} + {1'b0, tgt_new};
  assign cur_half  = cur_sum[RATE_W:1];
  assign cut       = prod_cut[37:17];
  assign cur_cnp   = (cut > minr) ? cut : minr;
  assign cur_final = (item.op == OP_CNP) ? cur_cnp[RATE_W-1:0] : cur_tick;
  assign timer     = (item.op == OP_CNP) || (cur_final < line_eff) || (alpha_new != '0);
  assign stage_final = (item.op == OP_CNP) ? '0 :
                       (rd_data.stage == STAGE_MAX) ? rd_data.stage : rd_data.stage + 1'b1;

  always_ff @(posedge clk) begin
    case (state)
      BK_READ: begin
        prod_alpha <= one_minus_g * rd_data.alpha;
        prod_min   <= line_eff * frac_eff;
      end
      BK_CALC: begin
        alpha_new <= (item.op == OP_CNP) ? alpha_c : alpha_t;
        minr      <= (minr_raw == '0) ? (RATE_W + 1)'(1) : minr_raw;
        tgt_new   <= (item.op == OP_CNP) ? rd_data.cur : tgt_t;
      end
      BK_CUT: begin
        prod_cut <= rd_data.cur * (TWO_Q16 - {1'b0, alpha_new});
        cur_tick <= (cur_half > line_eff) ? line_eff : cur_half;
      end
      default: begin
      end
    endcase
  end

  assign entry_new.alpha = alpha_new;
  assign entry_new.cur   = cur_final;
  assign entry_new.tgt   = tgt_new;
  assign entry_new.stage = stage_final;

  assign out_next.flow_echo    = item.flow;
  assign out_next.current_rate = cur_final;
  assign out_next.target_rate  = tgt_new;
  assign out_next.alpha_level  = alpha_new;
  assign out_next.start_timer  = timer;

  always_ff @(posedge clk) begin
    if (out_load) begin
      update <= out_next;
    end
  end

  assign empty = !out_valid;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    bstat.clearing |-> !q_pop)
    else $error("queue popped during clearing pass");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result lost after load");

  a_cnp_result: assert property (@(posedge clk) disable iff (rst)
    (out_load && item.op == OP_CNP) |-> (out_next.start_timer && out_next.current_rate != '0))
    else $error("notification result without timer or with zero rate");

  a_hold_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE && !slot_free) |-> !mem_we)
    else $error("state written while result slot busy");

endmodule

FILE: hdl/dcqcn_rate_controller.sv
// ----------------------------------------------------------------------------
// dcqcn_rate_controller
// Per-flow DCQCN reaction point: congestion notifications and recovery
// ticks update alpha, current rate, target rate and recovery stage.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  events    push / full           notice  (op, flow_index)
//  results   pop / empty           update  (flow_echo .. start_timer)
//  config    psel/penable/pwrite   paddr, pwdata, prdata, pready
//
//  the back sequencer takes one item at a time through memory read, two dependent
//  multiplies (alpha, then the rate cut) and the write-back
//  after reset a clearing pass over all FLOWS entries holds full high
//  a two-entry queue lets events arrive while the back works
//  a finished result waits in the output register; the back holds its
//  last step until that register is free
//  events for flows at or above FLOWS are dropped without a result
// ----------------------------------------------------------------------------
module dcqcn_rate_controller
  import dcqcn_rc_pkg::*;
#(
  parameter int FLOWS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  evt_t              notice,
  output logic              empty,
  input  logic              pop,
  output upd_t              update,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  qstat_t qstat;
  bstat_t bstat;
  logic   q_wr;
  cls_t   q_item;
  logic   q_pop;
  cls_t   q_head;

  dcqcn_rc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dcqcn_rc_front #(.FLOWS(FLOWS)) u_front (
    .push   (push),
    .full   (full),
    .notice (notice),
    .qstat  (qstat),
    .bstat  (bstat),
    .q_wr   (q_wr),
    .q_item (q_item)
  );

  dcqcn_rc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (q_item),
    .rd      (q_pop),
    .rd_item (q_head),
    .stat    (qstat)
  );

  dcqcn_rc_back #(.FLOWS(FLOWS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .qstat  (qstat),
    .q_head (q_head),
    .q_pop  (q_pop),
    .bstat  (bstat),
    .empty  (empty),
    .pop    (pop),
    .update (update)
  );

endmodule
